### sv/rbts_pkg.sv
// rbts_pkg: shared widths, reset values, codes and types of the rolling band trade signal.
// No dependencies; every other file of the block refers to it by scoped names.
package rbts_pkg;

  localparam int unsigned PriceW    = 24;
  localparam int unsigned WinW      = 7;
  localparam int unsigned MaxPosW   = 8;
  localparam int unsigned MultW     = 12;
  localparam int unsigned PosW      = 9;
  localparam int unsigned CashW     = 48;
  localparam int unsigned SumW      = 31;
  localparam int unsigned SqSumW    = 55;
  localparam int unsigned RingDepth = 64;
  localparam int unsigned AddrW     = $clog2(RingDepth);
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 12;
  localparam int unsigned QueueDepth = 2;

  localparam logic [WinW-1:0]    WindowLenRst = 7'd20;
  localparam logic [MaxPosW-1:0] MaxPosRst    = 8'd5;
  localparam logic [MultW-1:0]   BandMultRst  = 12'd512;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowLen   = 2'd0,
    CfgMaxPosition = 2'd1,
    CfgBandMult    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActHold = 2'd0,
    ActBuy  = 2'd1,
    ActSell = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_OLD,
    F_NEW,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIFF,
    B_DD,
    B_SS,
    B_NQL,
    B_NQH,
    B_BB,
    B_VL,
    B_VH,
    B_CMP,
    B_TRADE,
    B_MARK,
    B_OUT
  } back_state_e;

  // one classified sample as handed from the window front end to the decision back end
  typedef struct packed {
    logic [PriceW-1:0] price;
    logic [SumW-1:0]   sum;
    logic [SqSumW-1:0] sq_sum;
    logic [WinW-1:0]   n;
    logic              warm;
  } item_t;

endpackage

### sv/rbts_fifo.sv
// rbts_fifo: short register queue of window items between front and back end.
// Depends on rbts_pkg for the item type and the queue depth.
module rbts_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rbts_pkg::item_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rbts_pkg::item_t data_o
);

  localparam int unsigned PtrW = (rbts_pkg::QueueDepth > 1) ? $clog2(rbts_pkg::QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(rbts_pkg::QueueDepth + 1);

  rbts_pkg::item_t entry_q [rbts_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(rbts_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(rbts_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(rbts_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### sv/rbts_front.sv
// rbts_front: accepts price samples, keeps the price ring and the running sum and
// sum of squares, and queues each sample with its window figures. Depends on rbts_pkg.
module rbts_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rbts_pkg::PriceW-1:0]   price_i,
  input  logic [rbts_pkg::WinW-1:0]     window_len_i,
  input  logic                          restart_i,
  output logic                          q_push_o,
  input  logic                          q_full_i,
  output rbts_pkg::item_t               q_data_o
);

  rbts_pkg::front_state_e state_q, state_d;

  logic [rbts_pkg::PriceW-1:0] ring_q [rbts_pkg::RingDepth];
  logic [rbts_pkg::PriceW-1:0] rd_q;
  logic [rbts_pkg::AddrW-1:0]  head_q;
  logic [rbts_pkg::AddrW-1:0]  rd_addr;
  logic [rbts_pkg::WinW-1:0]   seen_q;
  logic [rbts_pkg::SumW-1:0]   sum_q;
  logic [rbts_pkg::SqSumW-1:0] sq_sum_q;
  logic [rbts_pkg::SqSumW-1:0] sq_q;
  logic [rbts_pkg::SqSumW-1:0] sq_sum_new;
  logic [rbts_pkg::PriceW-1:0] price_q;
  logic                        warm_q;
  logic [rbts_pkg::SumW-1:0]   old_term;
  logic [2*rbts_pkg::PriceW-1:0] old_sq;
  logic [2*rbts_pkg::PriceW-1:0] new_sq;
  logic                        accept;

  // entry leaving the window sits n places behind the head
  assign rd_addr    = head_q - window_len_i[rbts_pkg::AddrW-1:0];
  assign accept     = in_valid_i && (state_q == rbts_pkg::F_IDLE);
  assign in_stall_o = (state_q != rbts_pkg::F_IDLE);
  assign old_term   = warm_q ? {{(rbts_pkg::SumW - rbts_pkg::PriceW){1'b0}}, rd_q} : '0;
  assign old_sq     = rd_q * rd_q;
  assign new_sq     = price_q * price_q;
  assign sq_sum_new = sq_sum_q + sq_q;

  assign q_data_o.price  = price_q;
  assign q_data_o.sum    = sum_q;
  assign q_data_o.sq_sum = sq_sum_new;
  assign q_data_o.n      = window_len_i;
  assign q_data_o.warm   = warm_q;

  always_comb begin
    state_d  = state_q;
    q_push_o = 1'b0;
    unique case (state_q)
      rbts_pkg::F_IDLE: begin
        if (accept) begin
          state_d = rbts_pkg::F_OLD;
        end
      end
      rbts_pkg::F_OLD: begin
        state_d = rbts_pkg::F_NEW;
      end
      rbts_pkg::F_NEW: begin
        state_d = rbts_pkg::F_PUSH;
      end
      rbts_pkg::F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = rbts_pkg::F_IDLE;
        end
      end
      default: begin
        state_d = rbts_pkg::F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbts_pkg::F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      seen_q   <= '0;
      sum_q    <= '0;
      sq_sum_q <= '0;
    end else if (restart_i) begin
      seen_q   <= '0;
      sum_q    <= '0;
      sq_sum_q <= '0;
    end else begin
      if (accept) begin
        head_q <= head_q + 1'b1;
        if (seen_q < rbts_pkg::WinW'(rbts_pkg::RingDepth)) begin
          seen_q <= seen_q + 1'b1;
        end
      end
      unique case (state_q)
        rbts_pkg::F_OLD: begin
          sum_q <= sum_q - old_term + {{(rbts_pkg::SumW - rbts_pkg::PriceW){1'b0}}, price_q};
        end
        rbts_pkg::F_NEW: begin
          sq_sum_q <= sq_sum_q - sq_q;
        end
        rbts_pkg::F_PUSH: begin
          if (q_push_o) begin
            sq_sum_q <= sq_sum_new;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_q <= price_i;
      warm_q  <= (seen_q >= window_len_i);
    end
    unique case (state_q)
      rbts_pkg::F_OLD: begin
        sq_q <= warm_q ? {{(rbts_pkg::SqSumW - 2*rbts_pkg::PriceW){1'b0}}, old_sq} : '0;
      end
      rbts_pkg::F_NEW: begin
        sq_q <= {{(rbts_pkg::SqSumW - 2*rbts_pkg::PriceW){1'b0}}, new_sq};
      end
      default: ;
    endcase
  end

  // read-first ring: with a full-depth window the leaving entry is the one overwritten
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring_q[head_q] <= price_i;
      rd_q           <= ring_q[rd_addr];
    end
  end

endmodule

### sv/rbts_back.sv
// rbts_back: band test on one shared 32x32 multiplier, trade decision, holding, cash,
// mark-to-market and the result register. Depends on rbts_pkg.
module rbts_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rbts_pkg::MaxPosW-1:0]  max_position_i,
  input  logic [rbts_pkg::MultW-1:0]    band_mult_i,
  input  rbts_pkg::item_t               q_data_i,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    action_o,
  output logic signed [rbts_pkg::PosW-1:0]  position_o,
  output logic signed [rbts_pkg::CashW-1:0] cashflow_o,
  output logic signed [rbts_pkg::CashW-1:0] marked_value_o,
  output logic                          warmed_up_o
);

  localparam int unsigned CmpW  = 85;
  localparam int unsigned MarkW = rbts_pkg::PosW + rbts_pkg::PriceW + 1;
  localparam logic [rbts_pkg::CashW-1:0] CashMax = {1'b0, {(rbts_pkg::CashW-1){1'b1}}};
  localparam logic [rbts_pkg::CashW-1:0] CashMin = {1'b1, {(rbts_pkg::CashW-1){1'b0}}};

  function automatic logic [rbts_pkg::CashW-1:0] sat_cash(logic [rbts_pkg::CashW:0] v);
    logic [rbts_pkg::CashW-1:0] r;
    if (v[rbts_pkg::CashW] != v[rbts_pkg::CashW-1]) begin
      r = v[rbts_pkg::CashW] ? CashMin : CashMax;
    end else begin
      r = v[rbts_pkg::CashW-1:0];
    end
    return r;
  endfunction

  rbts_pkg::back_state_e state_q, state_d;

  logic [rbts_pkg::PriceW-1:0] price_q;
  logic [rbts_pkg::SumW-1:0]   sum_q;
  logic [rbts_pkg::SqSumW-1:0] sq_sum_q;
  logic [rbts_pkg::WinW-1:0]   n_q;
  logic                        warm_q;
  logic [31:0]                 d_q;
  logic [31:0]                 d_mag;
  logic [rbts_pkg::SumW-1:0]   np;
  logic [31:0]                 mul_a, mul_b;
  logic [63:0]                 mul_p, prod_q;
  logic [CmpW-1:0]             lhs_q, rhs_q;
  logic [63:0]                 var_q;
  logic [23:0]                 bm2_q;
  logic                        outside_q;
  rbts_pkg::action_e           action_q;
  logic signed [rbts_pkg::PosW-1:0] hold_q;
  logic signed [rbts_pkg::PosW-1:0] pos_max, neg_max;
  logic [rbts_pkg::CashW-1:0]  cash_q;
  logic signed [MarkW-1:0]     mark_q;
  logic [rbts_pkg::CashW:0]    cash_buy, cash_sell, mark_sum;
  logic                        buy, sell, load_out;

  rbts_pkg::action_e           act_out_q;
  logic signed [rbts_pkg::PosW-1:0]  pos_out_q;
  logic [rbts_pkg::CashW-1:0]  cash_out_q;
  logic [rbts_pkg::CashW-1:0]  mv_out_q;
  logic                        warm_out_q;
  logic                        out_valid_q;

  assign np      = {{(rbts_pkg::SumW - rbts_pkg::WinW){1'b0}}, n_q}
                 * {{(rbts_pkg::SumW - rbts_pkg::PriceW){1'b0}}, price_q};
  assign d_mag   = d_q[31] ? (32'd0 - d_q) : d_q;
  assign mul_p   = mul_a * mul_b;
  assign pos_max = $signed({1'b0, max_position_i});
  assign neg_max = $signed(9'd0 - {1'b0, max_position_i});
  assign buy     = !d_q[31] && (d_q != '0) && outside_q && (hold_q < pos_max);
  assign sell    = d_q[31] && outside_q && (hold_q > neg_max);

  assign cash_buy  = {cash_q[rbts_pkg::CashW-1], cash_q}
                   - {{(rbts_pkg::CashW + 1 - rbts_pkg::PriceW){1'b0}}, price_q};
  assign cash_sell = {cash_q[rbts_pkg::CashW-1], cash_q}
                   + {{(rbts_pkg::CashW + 1 - rbts_pkg::PriceW){1'b0}}, price_q};
  assign mark_sum  = {cash_q[rbts_pkg::CashW-1], cash_q}
                   + {{(rbts_pkg::CashW + 1 - MarkW){mark_q[MarkW-1]}}, mark_q};

  // sequencer: DD-VH load the shared multiplier, SS-CMP fold in the prior product
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    load_out = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      rbts_pkg::B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = q_data_i.warm ? rbts_pkg::B_DIFF : rbts_pkg::B_MARK;
        end
      end
      rbts_pkg::B_DIFF: begin
        state_d = rbts_pkg::B_DD;
      end
      rbts_pkg::B_DD: begin
        mul_a   = d_mag;
        mul_b   = d_mag;
        state_d = rbts_pkg::B_SS;
      end
      rbts_pkg::B_SS: begin
        mul_a   = {1'b0, sum_q};
        mul_b   = {1'b0, sum_q};
        state_d = rbts_pkg::B_NQL;
      end
      rbts_pkg::B_NQL: begin
        mul_a   = {25'd0, n_q};
        mul_b   = sq_sum_q[31:0];
        state_d = rbts_pkg::B_NQH;
      end
      rbts_pkg::B_NQH: begin
        mul_a   = {25'd0, n_q};
        mul_b   = {9'd0, sq_sum_q[54:32]};
        state_d = rbts_pkg::B_BB;
      end
      rbts_pkg::B_BB: begin
        mul_a   = {20'd0, band_mult_i};
        mul_b   = {20'd0, band_mult_i};
        state_d = rbts_pkg::B_VL;
      end
      rbts_pkg::B_VL: begin
        mul_a   = var_q[31:0];
        mul_b   = {8'd0, prod_q[23:0]};
        state_d = rbts_pkg::B_VH;
      end
      rbts_pkg::B_VH: begin
        mul_a   = {3'd0, var_q[60:32]};
        mul_b   = {8'd0, bm2_q};
        state_d = rbts_pkg::B_CMP;
      end
      rbts_pkg::B_CMP: begin
        state_d = rbts_pkg::B_TRADE;
      end
      rbts_pkg::B_TRADE: begin
        state_d = rbts_pkg::B_MARK;
      end
      rbts_pkg::B_MARK: begin
        state_d = rbts_pkg::B_OUT;
      end
      rbts_pkg::B_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = rbts_pkg::B_IDLE;
        end
      end
      default: begin
        state_d = rbts_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbts_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      cash_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == rbts_pkg::B_TRADE) && buy) begin
        hold_q <= hold_q + 9'sd1;
        cash_q <= sat_cash(cash_buy);
      end else if ((state_q == rbts_pkg::B_TRADE) && sell) begin
        hold_q <= hold_q - 9'sd1;
        cash_q <= sat_cash(cash_sell);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (q_pop_o) begin
      price_q  <= q_data_i.price;
      sum_q    <= q_data_i.sum;
      sq_sum_q <= q_data_i.sq_sum;
      n_q      <= q_data_i.n;
      warm_q   <= q_data_i.warm;
      action_q <= rbts_pkg::ActHold;
    end
    unique case (state_q)
      rbts_pkg::B_DIFF: begin
        d_q <= {1'b0, np} - {1'b0, sum_q};
      end
      rbts_pkg::B_SS: begin
        lhs_q <= {5'd0, prod_q, 16'd0};
      end
      rbts_pkg::B_NQL: begin
        var_q <= 64'd0 - prod_q;
      end
      rbts_pkg::B_NQH: begin
        var_q <= var_q + prod_q;
      end
      rbts_pkg::B_BB: begin
        var_q <= var_q + {prod_q[31:0], 32'd0};
      end
      rbts_pkg::B_VL: begin
        bm2_q <= prod_q[23:0];
      end
      rbts_pkg::B_VH: begin
        rhs_q <= {21'd0, prod_q};
      end
      rbts_pkg::B_CMP: begin
        // high partial of the variance times band_mult squared stays below 2^53
        outside_q <= lhs_q > (rhs_q + {prod_q[52:0], 32'd0});
      end
      rbts_pkg::B_TRADE: begin
        if (buy) begin
          action_q <= rbts_pkg::ActBuy;
        end else if (sell) begin
          action_q <= rbts_pkg::ActSell;
        end
      end
      rbts_pkg::B_MARK: begin
        mark_q <= hold_q * $signed({1'b0, price_q});
      end
      rbts_pkg::B_OUT: begin
        if (load_out) begin
          act_out_q  <= action_q;
          pos_out_q  <= hold_q;
          cash_out_q <= cash_q;
          mv_out_q   <= sat_cash(mark_sum);
          warm_out_q <= warm_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = act_out_q;
  assign position_o     = pos_out_q;
  assign cashflow_o     = cash_out_q;
  assign marked_value_o = mv_out_q;
  assign warmed_up_o    = warm_out_q;

endmodule

### sv/rolling_band_trade_signal_top.sv
// rolling_band_trade_signal_top: configuration registers and the front end, queue and
// back end of the band crossover trader. Depends on rbts_pkg, rbts_front, rbts_fifo, rbts_back.

// One price sample goes in per transaction and exactly one result comes out for it, in
// order. The front end takes no new sample until it has queued the last one (ring read,
// two squarings, queue push); the back end runs the band test as a sequence of steps on
// one shared 32x32 multiplier and skips it for a warm-up sample. A two-entry queue and
// the result register let input and output stall independently. Configuration writes
// take effect at once and are meant for an idle block; writing window_len restarts
// warm-up but keeps holding and cash.
module rolling_band_trade_signal_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rbts_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [rbts_pkg::CfgDataW-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [rbts_pkg::PriceW-1:0]        price_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         action_o,
  output logic signed [rbts_pkg::PosW-1:0]   position_o,
  output logic signed [rbts_pkg::CashW-1:0]  cashflow_o,
  output logic signed [rbts_pkg::CashW-1:0]  marked_value_o,
  output logic                               warmed_up_o
);

  logic [rbts_pkg::WinW-1:0]    window_len_q, window_len_d;
  logic [rbts_pkg::MaxPosW-1:0] max_pos_q;
  logic [rbts_pkg::MultW-1:0]   band_mult_q;
  logic [rbts_pkg::WinW-1:0]    win_wr;
  logic                         restart;

  rbts_pkg::item_t push_data, pop_data;
  logic            push, full, pop, empty;

  assign win_wr  = cfg_wdata_i[rbts_pkg::WinW-1:0];
  assign restart = cfg_we_i && (cfg_idx_i == rbts_pkg::CfgWindowLen);

  // zero means one, anything past the ring depth means the full ring
  always_comb begin
    if (win_wr == '0) begin
      window_len_d = rbts_pkg::WinW'(1);
    end else if (win_wr > rbts_pkg::WinW'(rbts_pkg::RingDepth)) begin
      window_len_d = rbts_pkg::WinW'(rbts_pkg::RingDepth);
    end else begin
      window_len_d = win_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= rbts_pkg::WindowLenRst;
      max_pos_q    <= rbts_pkg::MaxPosRst;
      band_mult_q  <= rbts_pkg::BandMultRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rbts_pkg::CfgWindowLen:   window_len_q <= window_len_d;
        rbts_pkg::CfgMaxPosition: max_pos_q    <= cfg_wdata_i[rbts_pkg::MaxPosW-1:0];
        rbts_pkg::CfgBandMult:    band_mult_q  <= cfg_wdata_i[rbts_pkg::MultW-1:0];
        default: ;
      endcase
    end
  end

  rbts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .price_i      (price_i),
    .window_len_i (window_len_q),
    .restart_i    (restart),
    .q_push_o     (push),
    .q_full_i     (full),
    .q_data_o     (push_data)
  );

  rbts_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (pop_data)
  );

  rbts_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_position_i (max_pos_q),
    .band_mult_i    (band_mult_q),
    .q_data_i       (pop_data),
    .q_empty_i      (empty),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .position_o     (position_o),
    .cashflow_o     (cashflow_o),
    .marked_value_o (marked_value_o),
    .warmed_up_o    (warmed_up_o)
  );

endmodule

### bench/rbts_trade_checker.sv
// rbts_trade_checker: watches the register port and both channels of the band crossover
// trader, predicts every result and compares it field by field with what comes out.
// Depends on rbts_pkg for widths, register indexes, reset values and action codes.
module rbts_trade_checker (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [rbts_pkg::CfgIdxW-1:0]                cfg_idx_i,
  input  logic [rbts_pkg::CfgDataW-1:0]               cfg_wdata_i,
  input  logic                                        in_valid_i,
  input  logic                                        in_stall_i,
  input  logic [rbts_pkg::PriceW-1:0]                 price_i,
  input  logic                                        out_valid_i,
  input  logic                                        out_stall_i,
  input  logic [1:0]                                  action_i,
  input  logic signed [rbts_pkg::PosW-1:0]            position_i,
  input  logic signed [rbts_pkg::CashW-1:0]           cashflow_i,
  input  logic signed [rbts_pkg::CashW-1:0]           marked_value_i,
  input  logic                                        warmed_up_i,
  output int                                          fail_count_o,
  output int                                          pending_o,
  output int                                          checked_o,
  output int                                          trades_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [63:0] CashHi = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] CashLo = -CashHi - 64'sd1;

  typedef struct packed {
    rbts_pkg::action_e                  act;
    logic signed [rbts_pkg::PosW-1:0]   pos;
    logic signed [rbts_pkg::CashW-1:0]  cash;
    logic signed [rbts_pkg::CashW-1:0]  mark;
    logic                               warm;
  } trade_result_t;

  trade_result_t expected_q[$];

  // predicted state of the block
  logic [rbts_pkg::PriceW-1:0]       ring [rbts_pkg::RingDepth];
  logic [rbts_pkg::AddrW-1:0]        head;
  logic [rbts_pkg::SumW-1:0]         sum_win;
  logic [rbts_pkg::SqSumW-1:0]       sq_win;
  logic [rbts_pkg::WinW-1:0]         seen_cnt;
  logic [rbts_pkg::WinW-1:0]         win_len;
  logic [rbts_pkg::MaxPosW-1:0]      pos_limit;
  logic [rbts_pkg::MultW-1:0]        band_mult;
  logic signed [rbts_pkg::PosW-1:0]  holding;
  logic signed [rbts_pkg::CashW-1:0] cash;

  int errors;
  int checked_cnt;
  int trade_cnt;
  trade_result_t head_res;
  logic [rbts_pkg::WinW-1:0] new_len;

  function automatic logic signed [rbts_pkg::CashW-1:0] clamp_cash(
      input logic signed [63:0] v);
    if (v > CashHi) return CashHi[rbts_pkg::CashW-1:0];
    if (v < CashLo) return CashLo[rbts_pkg::CashW-1:0];
    return v[rbts_pkg::CashW-1:0];
  endfunction

  function automatic trade_result_t trade_on_price(input logic [rbts_pkg::PriceW-1:0] p);
    trade_result_t r;
    logic [rbts_pkg::AddrW-1:0] old_idx;
    logic [63:0] old_p;
    logic warm;
    logic signed [63:0] d;
    logic signed [63:0] c;
    logic [63:0] ad;
    logic [127:0] lhs;
    logic [127:0] band_var;
    logic [127:0] rhs;
    logic outside;
    warm = (seen_cnt >= win_len);
    r.act = rbts_pkg::ActHold;
    if (warm) begin
      // the oldest sample of the window drops out
      old_idx = head - win_len[rbts_pkg::AddrW-1:0];
      old_p = 64'(ring[old_idx]);
      sum_win = sum_win - rbts_pkg::SumW'(old_p);
      sq_win = sq_win - rbts_pkg::SqSumW'(old_p * old_p);
    end
    sum_win = sum_win + rbts_pkg::SumW'(p);
    sq_win = sq_win + rbts_pkg::SqSumW'(64'(p) * 64'(p));
    ring[head] = p;
    head = head + 1'b1;
    if (seen_cnt < rbts_pkg::WinW'(rbts_pkg::RingDepth)) seen_cnt = seen_cnt + 1'b1;

    if (warm) begin
      d = 64'(win_len) * 64'(p) - 64'(sum_win);
      ad = (d < 0) ? 64'(-d) : 64'(d);
      // exact band test: d*d*65536 against mult^2 * (n*Q - S*S)
      lhs = (128'(ad) * 128'(ad)) << 16;
      band_var = 128'(win_len) * 128'(sq_win) - 128'(sum_win) * 128'(sum_win);
      rhs = band_var * 128'(32'(band_mult) * 32'(band_mult));
      outside = (lhs > rhs);
      if (d > 0 && outside && int'(holding) < int'(pos_limit)) begin
        r.act = rbts_pkg::ActBuy;
        holding = holding + 1'b1;
        c = cash;
        cash = clamp_cash(c - longint'(p));
      end else if (d < 0 && outside && int'(holding) > -int'(pos_limit)) begin
        r.act = rbts_pkg::ActSell;
        holding = holding - 1'b1;
        c = cash;
        cash = clamp_cash(c + longint'(p));
      end
    end
    c = cash;
    r.mark = clamp_cash(c + longint'(holding) * longint'(p));
    r.pos = holding;
    r.cash = cash;
    r.warm = warm;
    return r;
  endfunction

  task automatic compare_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbts_pkg::RingDepth; i++) ring[i] = '0;
      head = '0;
      sum_win = '0;
      sq_win = '0;
      seen_cnt = '0;
      win_len = rbts_pkg::WindowLenRst;
      pos_limit = rbts_pkg::MaxPosRst;
      band_mult = rbts_pkg::BandMultRst;
      holding = '0;
      cash = '0;
      expected_q.delete();
      errors = 0;
      checked_cnt = 0;
      trade_cnt = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      trades_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rbts_pkg::CfgWindowLen: begin
            new_len = cfg_wdata_i[rbts_pkg::WinW-1:0];
            if (new_len == '0) new_len = rbts_pkg::WinW'(1);
            if (new_len > rbts_pkg::WinW'(rbts_pkg::RingDepth)) begin
              new_len = rbts_pkg::WinW'(rbts_pkg::RingDepth);
            end
            win_len = new_len;
            // warm-up starts over, holding and cash stay
            sum_win = '0;
            sq_win = '0;
            seen_cnt = '0;
          end
          rbts_pkg::CfgMaxPosition: pos_limit = cfg_wdata_i[rbts_pkg::MaxPosW-1:0];
          rbts_pkg::CfgBandMult: band_mult = cfg_wdata_i[rbts_pkg::MultW-1:0];
          default: ;
        endcase
      end

      // results first, so a transaction taken in this cycle cannot be matched yet
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none, actual action %0d",
                   $time, action_i);
        end else begin
          head_res = expected_q.pop_front();
          compare_field("action", 64'(head_res.act), 64'(action_i));
          compare_field("position", head_res.pos, position_i);
          compare_field("cashflow", head_res.cash, cashflow_i);
          compare_field("marked_value", head_res.mark, marked_value_i);
          compare_field("warmed_up", 64'(head_res.warm), 64'(warmed_up_i));
          checked_cnt++;
        end
      end

      if (in_valid_i && !in_stall_i) begin
        head_res = trade_on_price(price_i);
        if (head_res.act != rbts_pkg::ActHold) trade_cnt++;
        expected_q.insert(expected_q.size(), head_res);
      end

      fail_count_o <= errors;
      pending_o <= expected_q.size();
      checked_o <= checked_cnt;
      trades_o <= trade_cnt;
    end
  end

endmodule

### bench/rolling_band_trade_signal_top_tb.sv
// rolling_band_trade_signal_top_tb: price stimulus, register settings, output stalls and
// verdict for the band crossover trader. Depends on rbts_pkg, the block and rbts_trade_checker.
module rolling_band_trade_signal_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 4000;
  localparam int Phases = 10;
  localparam int PricesPerPhase = 185;
  localparam int PriceMax = 2 ** rbts_pkg::PriceW - 1;
  localparam logic [rbts_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                              clk_i;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we = 1'b0;
  logic [rbts_pkg::CfgIdxW-1:0]      cfg_idx = '0;
  logic [rbts_pkg::CfgDataW-1:0]     cfg_wdata = '0;
  logic                              in_valid = 1'b0;
  logic [rbts_pkg::PriceW-1:0]       price = '0;
  logic                              out_stall = 1'b0;
  logic                              in_stall;
  logic                              out_valid;
  logic [1:0]                        action;
  logic signed [rbts_pkg::PosW-1:0]  position;
  logic signed [rbts_pkg::CashW-1:0] cashflow;
  logic signed [rbts_pkg::CashW-1:0] marked_value;
  logic                              warmed_up;

  int fail_count;
  int pending;
  int checked;
  int trades;
  int prices_sent = 0;
  int settings_used = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_pick;
  int level;
  logic stall_on = 1'b1;
  logic no_idle = 1'b0;

  logic [rbts_pkg::CfgDataW-1:0] win_set [Phases];
  logic [rbts_pkg::CfgDataW-1:0] pos_set [Phases];
  logic [rbts_pkg::CfgDataW-1:0] mult_set [Phases];

  rolling_band_trade_signal_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .price_i        (price),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .action_o       (action),
    .position_o     (position),
    .cashflow_o     (cashflow),
    .marked_value_o (marked_value),
    .warmed_up_o    (warmed_up)
  );

  rbts_trade_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .price_i        (price),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .action_i       (action),
    .position_i     (position),
    .cashflow_i     (cashflow),
    .marked_value_i (marked_value),
    .warmed_up_i    (warmed_up),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .trades_o       (trades)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side back-pressure: mostly short bursts, now and then a long hold
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(3, 12);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // drifting price with jumps that break out of the band, plus raw and extreme values
  function automatic logic [rbts_pkg::PriceW-1:0] next_price();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
    if (r < 10) return rbts_pkg::PriceW'($urandom());
    if (r < 18) begin
      level = level + (($urandom_range(0, 1) != 0) ? 1 : -1)
                    * int'($urandom_range(1000, 200000));
    end else begin
      level = level + int'($urandom_range(0, 400)) - 200;
    end
    if (level < 0) level = 0;
    if (level > PriceMax) level = PriceMax;
    return rbts_pkg::PriceW'(level);
  endfunction

  task automatic send_price(input logic [rbts_pkg::PriceW-1:0] p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    price <= p;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    prices_sent++;
  endtask

  // hold the sender until every predicted result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [rbts_pkg::CfgDataW-1:0] win,
                            input logic [rbts_pkg::CfgDataW-1:0] max_pos,
                            input logic [rbts_pkg::CfgDataW-1:0] mult);
    cfg_we <= 1'b1;
    cfg_idx <= rbts_pkg::CfgWindowLen;
    cfg_wdata <= win;
    @(posedge clk_i);
    cfg_idx <= rbts_pkg::CfgMaxPosition;
    cfg_wdata <= max_pos;
    @(posedge clk_i);
    cfg_idx <= rbts_pkg::CfgBandMult;
    cfg_wdata <= mult;
    @(posedge clk_i);
    // unused index, must leave every register alone
    cfg_idx <= CfgUnused;
    cfg_wdata <= rbts_pkg::CfgDataW'($urandom());
    @(posedge clk_i);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    win_set  = '{12'd5, 12'd20, 12'hFFF, 12'd3, 12'd64, 12'd10, 12'd2, 12'h0C8, 12'd40, 12'd33};
    pos_set  = '{12'd3, 12'd5, 12'd255, 12'd255, 12'd10, 12'd0, 12'd1, 12'd2, 12'd7, 12'd255};
    mult_set = '{12'd256, 12'd512, 12'd300, 12'd100, 12'd1024, 12'd0, 12'd4095, 12'd128,
                 12'd640, 12'd200};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // window of zero becomes one: the price alone, so never a trade
    set_config(12'd0, 12'd255, 12'd0);
    send_price(24'h000000);
    send_price(24'hFFFFFF);
    send_price(24'h5A5A5A);
    wait_idle();

    // two-sample window without a band: every move trades, capped at one unit each way
    set_config(12'd2, 12'd1, 12'd0);
    send_price(24'h000000);
    send_price(24'h000000);
    send_price(24'hFFFFFF);
    send_price(24'hFFFFFF);
    send_price(24'h000000);
    send_price(24'h000000);
    send_price(24'd5);
    send_price(24'd10);
    send_price(24'd3);
    send_price(24'd1);
    send_price(24'd0);
    wait_idle();

    // climb to a long holding, then drop the limit below it
    set_config(12'd2, 12'd4, 12'd128);
    send_price(24'd100);
    send_price(24'd100);
    send_price(24'd200);
    send_price(24'd300);
    send_price(24'd400);
    send_price(24'd500);
    send_price(24'd600);
    wait_idle();
    set_config(12'd2, 12'd1, 12'd128);
    send_price(24'd1000);
    send_price(24'd1000);
    send_price(24'd2000);
    send_price(24'd1500);

    for (int ph = 0; ph < Phases; ph++) begin
      wait_idle();
      set_config(win_set[ph], pos_set[ph], mult_set[ph]);
      level = $urandom_range(50000, 16000000);
      for (int k = 0; k < PricesPerPhase; k++) begin
        if (k % 40 == 0) begin
          no_idle = ($urandom_range(0, 3) == 0);
          stall_on <= !no_idle;
        end else if ($urandom_range(0, 149) == 0) begin
          wait_idle();
        end
        send_price(next_price());
      end
    end

    wait_idle();
    repeat (30) @(posedge clk_i);
    $display("run covered %0d prices under %0d register settings", prices_sent, settings_used);
    $display("%0d results compared, %0d of them buys or sells", checked, trades);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### rolling_band_trade_signal_top.f
sv/rbts_pkg.sv
sv/rbts_fifo.sv
sv/rbts_front.sv
sv/rbts_back.sv
sv/rolling_band_trade_signal_top.sv
bench/rbts_trade_checker.sv
bench/rolling_band_trade_signal_top_tb.sv
